[design/hbf_pkg.sv]
// Package for the 3x3 heightmap box filter: payload structs, queue entry,
// configuration constants and the divide-by-nine reciprocal.
// No dependencies.
`default_nettype none

package hbf_pkg;

   // Field widths
   localparam int SAMPLE_W     = 8;
   localparam int RESULT_W     = 16;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;

   // Position compare width: covers heights up to 8192 plus two flush rows
   localparam int POS_W = 14;

   // Window sums: one column of three bytes, and all nine bytes
   localparam int COLSUM_W = 10;
   localparam int SUM_W    = 12;

   // floor(sum * 256 / 9) = (sum * DIV9_MULT) >> DIV9_SHIFT, exact for sum < 4096
   localparam int                    PROD_W      = 32;
   localparam int                    DIV9_MULT_W = 21;
   localparam logic [DIV9_MULT_W-1:0] DIV9_MULT  = 21'd1864136;
   localparam int                    DIV9_SHIFT  = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   // Register indexes (paddr[2])
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // Register reset values
   localparam logic [CFG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 12'd2048;
   localparam logic [CFG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd2048;

   typedef struct packed {
      logic [SAMPLE_W-1:0] height_sample;
      logic                flush;
   } hbf_req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] filtered_height;
      logic                frame_last;
   } hbf_rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH_W-1:0]  image_width;
      logic [CFG_HEIGHT_W-1:0] image_height;
   } hbf_cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] center;
      logic                border;
      logic                last;
   } hbf_entry_type;

endpackage

`default_nettype wire

[design/hbf_front.sv]
// Front end of the box filter: raster position, line stores, 3x3 window sums
// and result classification. Pushes one entry per result into the queue.
// Depends on hbf_pkg.
`default_nettype none

module hbf_front
   import hbf_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hbf_cfg_type         cfg,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire hbf_req_type         req_data,
   input  wire logic [QCOUNT_W-1:0] q_count,
   output logic                     push,
   output hbf_entry_type            push_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
   localparam logic [POS_W-1:0] MAX_W_POS = POS_W'(MAX_WIDTH);
   localparam logic [POS_W-1:0] MAX_H_POS = POS_W'(MAX_HEIGHT);
   localparam logic [POS_W-1:0] MIN_SIZE  = POS_W'(3);
   localparam logic [POS_W-1:0] ONE       = POS_W'(1);
   localparam logic [POS_W-1:0] TWO       = POS_W'(2);

   // Raster position of the next transaction
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Stage register: transaction waiting for its line store data
   logic                  st_valid_ff;
   logic                  st_out_ff, st_border_ff, st_last_ff, st_fwd_ff;
   logic [COL_W-1:0]      st_col_ff;
   logic [SAMPLE_W-1:0]   st_sample_ff;
   logic [2*SAMPLE_W-1:0] rd_ff, fwd_ff;

   // Window: sums of the two older columns and the newest middle sample
   logic [COLSUM_W-1:0] csa_ff, csb_ff;
   logic [SAMPLE_W-1:0] midb_ff;

   // Line store: {upper, middle} per column
   logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];

   logic [POS_W-1:0] w_eff, h_eff, cx, rx, cur_col, cur_row;
   logic [POS_W-1:0] ocol, orow, col_inc;
   logic             restart, last, has_out, border, accept;
   logic [QCOUNT_W-1:0] used;

   logic [2*SAMPLE_W-1:0] pair;
   logic [SAMPLE_W-1:0]   top, mid;
   logic [COLSUM_W-1:0]   newcol;
   logic [SUM_W-1:0]      sum;

   // Reserve a queue slot for every transaction that may still push
   always_comb begin
      used      = q_count + QCOUNT_W'(st_valid_ff && st_out_ff);
      req_ready = (used < QCOUNT_W'(QUEUE_DEPTH));
      accept    = req_valid && req_ready;
   end

   // Clamp sizes, locate the transaction and classify its result
   always_comb begin
      w_eff = POS_W'(cfg.image_width);
      if (w_eff < MIN_SIZE) begin
         w_eff = MIN_SIZE;
      end else if (w_eff > MAX_W_POS) begin
         w_eff = MAX_W_POS;
      end
      h_eff = POS_W'(cfg.image_height);
      if (h_eff < MIN_SIZE) begin
         h_eff = MIN_SIZE;
      end else if (h_eff > MAX_H_POS) begin
         h_eff = MAX_H_POS;
      end

      cx      = POS_W'(col_ff);
      rx      = POS_W'(row_ff);
      restart = (cx >= w_eff) || (rx > h_eff + ONE);
      cur_col = restart ? '0 : cx;
      cur_row = restart ? '0 : rx;
      last    = (cur_row == h_eff + ONE) && (cur_col == '0);
      col_inc = cur_col + ONE;

      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = ROW_W'(cur_row + ONE);
      end else begin
         col_in = COL_W'(col_inc);
         row_in = ROW_W'(cur_row);
      end

      has_out = !((cur_row == '0) || ((cur_row == ONE) && (cur_col == '0)));
      if (cur_col != '0) begin
         orow = cur_row - ONE;
         ocol = cur_col - ONE;
      end else begin
         orow = cur_row - TWO;
         ocol = w_eff - ONE;
      end
      border = (orow == '0) || (orow >= h_eff - ONE) ||
               (ocol == '0) || (ocol >= w_eff - ONE);
   end

   // Column data, with the previous write forwarded when it hit this column
   always_comb begin
      pair   = st_fwd_ff ? fwd_ff : rd_ff;
      top    = pair[2*SAMPLE_W-1:SAMPLE_W];
      mid    = pair[SAMPLE_W-1:0];
      newcol = COLSUM_W'(top) + COLSUM_W'(mid) + COLSUM_W'(st_sample_ff);
      sum    = SUM_W'(csa_ff) + SUM_W'(csb_ff) + SUM_W'(newcol);

      push                = st_valid_ff && st_out_ff;
      push_data.sum       = sum;
      push_data.center    = midb_ff;
      push_data.border    = st_border_ff;
      push_data.last      = st_last_ff;
   end

   // Advance position and stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // Capture the transaction into the stage
   always_ff @(posedge clock) begin
      if (accept) begin
         st_col_ff    <= COL_W'(cur_col);
         st_sample_ff <= req_data.flush ? '0 : req_data.height_sample;
         st_out_ff    <= has_out;
         st_border_ff <= border;
         st_last_ff   <= last;
         st_fwd_ff    <= st_valid_ff && (st_col_ff == COL_W'(cur_col));
         fwd_ff       <= {mid, st_sample_ff};
      end
   end

   // Line store: read at accept, write back shifted column from the stage
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[COL_W'(cur_col)];
      end
      if (st_valid_ff) begin
         line_mem[st_col_ff] <= {mid, st_sample_ff};
      end
   end

   // Slide the window one column
   always_ff @(posedge clock) begin
      if (reset) begin
         csa_ff  <= '0;
         csb_ff  <= '0;
         midb_ff <= '0;
      end else if (st_valid_ff) begin
         csa_ff  <= csb_ff;
         csb_ff  <= newcol;
         midb_ff <= mid;
      end
   end

endmodule

`default_nettype wire

[design/hbf_queue.sv]
// Short FIFO between the front end and the back end of the box filter.
// Depends on hbf_pkg.
`default_nettype none

module hbf_queue
   import hbf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire hbf_entry_type  push_data,
   output logic [QCOUNT_W-1:0] count,
   output logic                pop_valid,
   input  wire logic           pop,
   output hbf_entry_type       pop_data
);

   hbf_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCOUNT_W-1:0] count_ff;

   always_comb begin
      count     = count_ff;
      pop_valid = (count_ff != '0);
      pop_data  = slot_ff[rd_ptr_ff];
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/hbf_back.sv]
// Back end of the box filter: divide the window sum by nine through a
// reciprocal multiply, pick border pass-through, and hold the result register.
// Depends on hbf_pkg.
`default_nettype none

module hbf_back
   import hbf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire hbf_entry_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output hbf_rsp_type        rsp_data
);

   logic                b1_valid_ff, b1_valid_in;
   logic [PROD_W-1:0]   b1_prod_ff;
   logic [SAMPLE_W-1:0] b1_center_ff;
   logic                b1_border_ff, b1_last_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   hbf_rsp_type rsp_data_ff, rsp_data_in;

   logic out_free, b1_adv;

   // Handshake between queue, multiply stage and result register
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      b1_adv       = b1_valid_ff && out_free;
      q_pop        = q_valid && (!b1_valid_ff || out_free);
      b1_valid_in  = q_pop ? 1'b1 : (b1_adv ? 1'b0 : b1_valid_ff);
      rsp_valid_in = b1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      rsp_data_in.filtered_height = b1_border_ff ? {b1_center_ff, {SAMPLE_W{1'b0}}}
                                                 : b1_prod_ff[DIV9_SHIFT +: RESULT_W];
      rsp_data_in.frame_last      = b1_last_ff;

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_prod_ff   <= PROD_W'(q_data.sum) * PROD_W'(DIV9_MULT);
         b1_center_ff <= q_data.center;
         b1_border_ff <= q_data.border;
         b1_last_ff   <= q_data.last;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (b1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

[design/heightmap_box_filter_3x3_top.sv]
// 3x3 box filter over an 8-bit heightmap stream, top level with register port.
// Throughput: one transaction per cycle while the queue has room; set by the
// single line store port pair. Results trail the raster by one row plus one
// column; image_width+1 flush transactions drain a frame. Reset clears position,
// window, queue and output state and restores both size registers to 2048; line
// stores are not cleared.
`default_nettype none

module heightmap_box_filter_3x3_top
   import hbf_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire hbf_req_type        req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output hbf_rsp_type             rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0]      prdata,
   output logic                    pready
);

   logic [CFG_WIDTH_W-1:0]  image_width_ff;
   logic [CFG_HEIGHT_W-1:0] image_height_ff;
   hbf_cfg_type             cfg;
   logic                    reg_write;

   logic [QCOUNT_W-1:0] q_count;
   logic                push, q_valid, q_pop;
   hbf_entry_type       push_data, q_data;

   // Register port decode
   always_comb begin
      pready    = 1'b1;
      reg_write = psel && penable && pwrite;
      case (paddr[2])
         REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height_ff);
         default:          prdata = '0;
      endcase
      cfg.image_width  = image_width_ff;
      cfg.image_height = image_height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (reg_write) begin
         case (paddr[2])
            REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   hbf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data)
   );

   hbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (q_count),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   hbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[tb/heightmap_box_filter_3x3_top_tb.sv]
// Self-checking testbench for heightmap_box_filter_3x3_top: a scoreboard class predicts
// every filtered height from the accepted samples and checks results in order.
// Depends on hbf_pkg and the heightmap_box_filter_3x3_top RTL.
module heightmap_box_filter_3x3_top_tb;
   import hbf_pkg::*;

   localparam int LINE_DEPTH     = 2048;
   localparam int ROWS_MAX       = 4096;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 280;
   localparam int CLAMP_ITEMS    = 60;

   // Predicts the 3x3 mean stream and holds the results still owed by the block
   class box_mean_scoreboard;
      logic [CFG_WIDTH_W-1:0]  width_reg;
      logic [CFG_HEIGHT_W-1:0] height_reg;
      bit [SAMPLE_W-1:0] upper_row [LINE_DEPTH];
      bit [SAMPLE_W-1:0] middle_row [LINE_DEPTH];
      bit [SAMPLE_W-1:0] win [9];
      int unsigned col_pos;
      int unsigned row_pos;
      hbf_rsp_type expected_heights [$];
      int mismatch_count;

      function new();
         width_reg = IMAGE_WIDTH_RESET;
         height_reg = IMAGE_HEIGHT_RESET;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         col_pos = 0;
         row_pos = 0;
         mismatch_count = 0;
      endfunction

      function int unsigned cur_width();
         if (width_reg < 3) return 3;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return width_reg;
      endfunction

      function int unsigned cur_height();
         if (height_reg < 3) return 3;
         if (height_reg > ROWS_MAX) return ROWS_MAX;
         return height_reg;
      endfunction

      function bit at_frame_start();
         return (col_pos == 0) && (row_pos == 0);
      endfunction

      function void set_register(logic index, logic [PDATA_W-1:0] word);
         if (index == REG_IMAGE_WIDTH) width_reg = word[CFG_WIDTH_W-1:0];
         else height_reg = word[CFG_HEIGHT_W-1:0];
      endfunction

      // Advance the raster by one transaction and queue the result it completes
      function void take_sample(hbf_req_type item);
         int unsigned w, h, col, row, orow, ocol, total, i;
         bit [SAMPLE_W-1:0] sample, top, mid;
         bit last;
         hbf_rsp_type res;
         w = cur_width();
         h = cur_height();
         if (col_pos >= w || row_pos > h + 1) begin
            col_pos = 0;
            row_pos = 0;
         end
         col = col_pos;
         row = row_pos;
         sample = item.flush ? '0 : item.height_sample;

         // shift the line stores and the window
         top = upper_row[col];
         mid = middle_row[col];
         upper_row[col] = mid;
         middle_row[col] = sample;
         for (i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = sample;

         last = (row == h + 1) && (col == 0);
         if (last) begin
            col_pos = 0;
            row_pos = 0;
         end else if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = row + 1;
         end else begin
            col_pos = col + 1;
         end

         // the first row plus one column of a frame completes nothing
         if (row == 0 || (row == 1 && col == 0)) return;
         if (col >= 1) begin
            orow = row - 1;
            ocol = col - 1;
         end else begin
            orow = row - 2;
            ocol = w - 1;
         end
         if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
            res.filtered_height = {win[4], 8'h00};
         end else begin
            total = 0;
            for (i = 0; i < 9; i++) total += win[i];
            res.filtered_height = RESULT_W'((total * 256) / 9);
         end
         res.frame_last = last;
         expected_heights = {expected_heights, res};
      endfunction

      // Compare one result transaction with the oldest prediction
      function void check_filtered(hbf_rsp_type got);
         hbf_rsp_type want;
         if (expected_heights.size() == 0) begin
            $error("unexpected result: filtered_height %0d frame_last %0d",
                   got.filtered_height, got.frame_last);
            mismatch_count++;
            return;
         end
         want = expected_heights.pop_front();
         if (got.filtered_height !== want.filtered_height) begin
            $error("filtered_height: expected %0d, actual %0d",
                   want.filtered_height, got.filtered_height);
            mismatch_count++;
         end
         if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hbf_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hbf_rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   box_mean_scoreboard sb = new();
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;

   heightmap_box_filter_3x3_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Check result transactions and stall the result channel at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_filtered(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stop a hung run: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] draw_height();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return SAMPLE_W'($urandom_range(255));
      endcase
   endfunction

   // Offer one sample transaction, with an optional gap, and hold it until accepted
   task automatic send_item(input hbf_req_type item);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_sample(item);
      items_sent++;
   endtask

   task automatic send_raw(input logic [SAMPLE_W-1:0] height, input logic flush);
      hbf_req_type item;
      item.height_sample = height;
      item.flush = flush;
      send_item(item);
   endtask

   // Drop valid and wait until every predicted result has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_heights.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; bits above the field are random
   task automatic write_register(input logic index, input logic [CFG_HEIGHT_W-1:0] value);
      logic [PDATA_W-1:0] word;
      word = $urandom;
      if (index == REG_IMAGE_WIDTH) word[CFG_WIDTH_W-1:0] = value[CFG_WIDTH_W-1:0];
      else word[CFG_HEIGHT_W-1:0] = value;
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_register(index, word);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Pad with flush transactions until the raster is back at the frame start
   task automatic finish_frame();
      while (!sb.at_frame_start()) send_raw(draw_height(), 1'b1);
   endtask

   // One frame plus its drain; with breaks on, a few frames are cut short or overrun
   task automatic send_frame(input bit allow_breaks);
      int unsigned w, h, area, i;
      int total;
      int saved_send, saved_recv;
      w = sb.cur_width();
      h = sb.cur_height();
      area = w * h;
      total = area + w + 1;
      saved_send = send_gap_pct;
      saved_recv = recv_stall_pct;
      if (allow_breaks && $urandom_range(7) == 0) begin
         if ($urandom_range(1) == 0) total += $urandom_range(1, 2 * w);
         else total -= $urandom_range(1, w);
      end
      if ($urandom_range(3) == 0) begin
         send_gap_pct = 0;
         recv_stall_pct = 0;
      end
      for (i = 0; i < total; i++) begin
         if (i < area) send_raw(draw_height(), $urandom_range(39) == 0);
         else send_raw(draw_height(), $urandom_range(9) != 0);
      end
      send_gap_pct = saved_send;
      recv_stall_pct = saved_recv;
   endtask

   function automatic logic [CFG_HEIGHT_W-1:0] draw_size(input int unsigned top_typical);
      case ($urandom_range(19))
         0, 1: return CFG_HEIGHT_W'($urandom_range(2));
         2: return CFG_HEIGHT_W'($urandom_range(top_typical + 1, 3 * top_typical));
         default: return CFG_HEIGHT_W'($urandom_range(3, top_typical));
      endcase
   endfunction

   // Random frames at random sizes; sizes change only between whole frames
   task automatic run_phase(input int send_pct, input int recv_pct);
      int unsigned start_count;
      send_gap_pct = send_pct;
      recv_stall_pct = recv_pct;
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
         wait_drained();
         if ($urandom_range(3) != 0) write_register(REG_IMAGE_WIDTH, draw_size(12));
         if ($urandom_range(3) != 0) write_register(REG_IMAGE_HEIGHT, draw_size(8));
         send_frame(1'b1);
         finish_frame();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: 6 wide, height below range, part of a frame with a flush inside it
      write_register(REG_IMAGE_WIDTH, 13'd6);
      write_register(REG_IMAGE_HEIGHT, 13'd1);
      send_raw(8'h00, 1'b0);
      send_raw(8'hFF, 1'b0);
      send_raw(8'h55, 1'b0);
      send_raw(8'hAA, 1'b0);
      send_raw(8'h0F, 1'b0);
      send_raw(8'hF0, 1'b0);
      send_raw(8'hFF, 1'b0);
      send_raw(8'hFF, 1'b1);
      send_raw(8'h00, 1'b0);
      send_raw(8'h01, 1'b0);

      // Shrink the width in mid-frame: the stale column restarts the frame
      wait_drained();
      write_register(REG_IMAGE_WIDTH, 13'd2);

      // Full-scale 3x3 frame, a sample sent where a flush belongs, then end of frame
      repeat (9) send_raw(8'hFF, 1'b0);
      send_raw(8'h00, 1'b1);
      send_raw(8'hA5, 1'b0);
      send_raw(8'h3C, 1'b1);
      send_raw(8'hC3, 1'b1);

      run_phase(33, 62);
      run_phase(62, 33);
      run_phase(0, 0);

      // Largest sizes through clamped register values: part of a frame at each
      wait_drained();
      write_register(REG_IMAGE_WIDTH, 13'd4095);
      write_register(REG_IMAGE_HEIGHT, 13'd2);
      repeat (CLAMP_ITEMS) send_raw(draw_height(), 1'b0);
      wait_drained();
      write_register(REG_IMAGE_WIDTH, 13'd1);
      write_register(REG_IMAGE_HEIGHT, 13'd8191);
      repeat (CLAMP_ITEMS) send_raw(draw_height(), 1'b0);

      wait_drained();
      if (sb.mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
design/hbf_pkg.sv
design/hbf_front.sv
design/hbf_queue.sv
design/hbf_back.sv
design/heightmap_box_filter_3x3_top.sv
tb/heightmap_box_filter_3x3_top_tb.sv
